/* rtl/dss_pkg.sv */
// Package for the drum step sequencer: word types, codes and shared constants.
`timescale 1ns / 1ps

package dss_pkg;

	// Default grid size
	localparam int TRACKS_DEF = 8;
	localparam int STEPS_DEF  = 16;

	// Step counter reduction: fold, reciprocal quotient, remainder, in that order
	localparam int COUNT_W   = 32;
	localparam int MOD_ITERS = 3;
	localparam int ITER_W    = $clog2(MOD_ITERS);

	// Configuration registers
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY = 1'd1;
	localparam logic [7:0] GATE_RESET     = 8'd3;
	localparam logic [6:0] VELOCITY_RESET = 7'd100;

	// Command modes
	localparam logic [2:0] MODE_STEP   = 3'd0;
	localparam logic [2:0] MODE_TOGGLE = 3'd1;
	localparam logic [2:0] MODE_QUERY  = 3'd2;
	localparam logic [2:0] MODE_CLEAR  = 3'd3;
	localparam logic [2:0] MODE_STOP   = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_TRIG  = 2'd0;
	localparam logic [1:0] KIND_OFF   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// Command word
	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] step_count;
		logic [2:0]  track_sel;
		logic [3:0]  step_sel;
	} cmd_word_t;

	// Note word
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] track_out;
		logic [6:0] velocity_out;
		logic [7:0] gate_out;
		logic       cell_on;
		logic       last;
	} note_word_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic mod_run;
		logic col_load;
		logic emit;
		logic emit_query;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mod_done;
		logic pend_empty;
		logic pend_last;
		logic slot_free;
	} dp_sts_t;

endpackage

/* rtl/drum_step_sequencer.sv */
// Drum step sequencer: TRACKS x STEPS pattern grid with step, toggle, query, clear and stop.
// Toggle, clear and unknown modes act on the accept cycle; a query waits for a free output
// slot and then registers its word. A step reduces the 32-bit step number (fold, quotient,
// remainder), reads the column, then gives one trigger word a cycle while the output is free,
// none for an empty column. Stop gives one note-off word per track alike; one command at a time.
// Reset clears the grid, the control state and the output, and loads gate 3, velocity 100.
`timescale 1ns / 1ps

module drum_step_sequencer #(
	parameter int TRACKS = dss_pkg::TRACKS_DEF,
	parameter int STEPS  = dss_pkg::STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  dss_pkg::cmd_word_t             cmd,
	output logic                           note_valid,
	input  logic                           note_ready,
	output dss_pkg::note_word_t            note,
	input  logic                           cfg_we,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dss_pkg::CFG_W-1:0]      cfg_data
);

	dss_pkg::ctl_cmd_t ctl;
	dss_pkg::dp_sts_t  sts;

	// Controller
	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.mode      (cmd.mode),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath
	dss_datapath #(
		.TRACKS (TRACKS),
		.STEPS  (STEPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.note_valid (note_valid),
		.note_ready (note_ready),
		.note       (note)
	);

endmodule

/* rtl/dss_ctrl.sv */
// Controller state machine of the drum step sequencer.
`timescale 1ns / 1ps

module dss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        mode,
	input  dss_pkg::dp_sts_t  sts,
	output dss_pkg::ctl_cmd_t ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_COL  = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_QRY  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		cmd_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					unique case (mode)
						dss_pkg::MODE_STEP:  state_d = ST_MOD;
						dss_pkg::MODE_QUERY: state_d = ST_QRY;
						dss_pkg::MODE_STOP:  state_d = ST_EMIT;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_MOD: begin
				ctl.mod_run = 1'b1;
				if (sts.mod_done)
					state_d = ST_COL;
			end
			ST_COL: begin
				ctl.col_load = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				// empty column ends the step with no word
				if (sts.pend_empty) begin
					state_d = ST_IDLE;
				end else if (sts.slot_free) begin
					ctl.emit = 1'b1;
					if (sts.pend_last)
						state_d = ST_IDLE;
				end
			end
			ST_QRY: begin
				if (sts.slot_free) begin
					ctl.emit_query = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/dss_datapath.sv */
// Datapath of the drum step sequencer: grid, step reduction, track scan, output register.
`timescale 1ns / 1ps

module dss_datapath #(
	parameter int TRACKS = dss_pkg::TRACKS_DEF,
	parameter int STEPS  = dss_pkg::STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dss_pkg::ctl_cmd_t              ctl,
	output dss_pkg::dp_sts_t               sts,
	input  dss_pkg::cmd_word_t             cmd,
	input  logic                           cfg_we,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dss_pkg::CFG_W-1:0]      cfg_data,
	output logic                           note_valid,
	input  logic                           note_ready,
	output dss_pkg::note_word_t            note
);

	localparam int RW  = $clog2(STEPS);
	localparam int TRW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	// Reduction constants: fold the upper half onto the lower, then exact reciprocal
	localparam int     HALF_W = dss_pkg::COUNT_W / 2;
	localparam int     FOLD_W = HALF_W + 6;
	localparam int     HI_MOD = (1 << HALF_W) % STEPS;
	localparam int     SHIFT  = FOLD_W + RW;
	localparam longint RECIP  = ((longint'(1) << SHIFT) + longint'(STEPS) - 1) / longint'(STEPS);
	localparam int     PROD_W = 2 * FOLD_W + 1;

	logic [STEPS-1:0]               grid_q [TRACKS];
	logic [7:0]                     gate_q;
	logic [6:0]                     vel_q;
	logic [dss_pkg::COUNT_W-1:0]    cnt_q;
	logic [FOLD_W-1:0]              fold_q;
	logic [FOLD_W-1:0]              quo_q;
	logic [RW-1:0]                  rem_q;
	logic [dss_pkg::ITER_W-1:0]     iter_q;
	logic [2:0]                     trk_sel_q;
	logic [3:0]                     stp_sel_q;
	logic [1:0]                     kind_q;
	logic [TRACKS-1:0]              pend_q;
	logic                           out_valid_q;
	dss_pkg::note_word_t            out_q;

	logic [FOLD_W-1:0]              fold_next;
	logic [PROD_W-1:0]              prod;
	logic [FOLD_W-1:0]              quo_next;
	logic [RW-1:0]                  rem_next;
	logic [TRACKS-1:0]              col_vec;
	logic [TRACKS-1:0]              pend_rest;
	logic [TRW-1:0]                 low_idx;
	logic                           in_cell_ok;
	logic                           q_cell_ok;
	logic                           q_cell;
	logic                           slot_free;

	// Cell range checks
	assign in_cell_ok = (int'(cmd.track_sel) < TRACKS) && (int'(cmd.step_sel) < STEPS);
	assign q_cell_ok  = (int'(trk_sel_q) < TRACKS) && (int'(stp_sel_q) < STEPS);
	assign q_cell     = q_cell_ok ? grid_q[TRW'(trk_sel_q)][RW'(stp_sel_q)] : 1'b0;

	// Step reduction: fold, quotient by reciprocal, remainder; one stage a cycle
	assign fold_next = FOLD_W'(cnt_q[dss_pkg::COUNT_W-1:HALF_W]) * FOLD_W'(HI_MOD)
		+ FOLD_W'(cnt_q[HALF_W-1:0]);
	assign prod      = PROD_W'(fold_q) * PROD_W'(RECIP);
	assign quo_next  = FOLD_W'(prod >> SHIFT);
	assign rem_next  = RW'(fold_q - quo_q * FOLD_W'(STEPS));

	// Column of the grid at the reduced step
	always_comb begin
		for (int t = 0; t < TRACKS; t++)
			col_vec[t] = grid_q[t][rem_q];
	end

	// Lowest pending track and what remains after it
	always_comb begin
		low_idx = '0;
		for (int i = TRACKS - 1; i >= 0; i--)
			if (pend_q[i])
				low_idx = TRW'(i);
	end
	assign pend_rest = pend_q & (pend_q - TRACKS'(1));

	assign slot_free      = !out_valid_q || note_ready;
	assign sts.mod_done   = (iter_q == dss_pkg::ITER_W'(dss_pkg::MOD_ITERS - 1));
	assign sts.pend_empty = (pend_q == '0);
	assign sts.pend_last  = (pend_rest == '0);
	assign sts.slot_free  = slot_free;

	// Pattern grid: toggle and clear act on the accept cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TRACKS; t++)
				grid_q[t] <= '0;
		end else if (ctl.load) begin
			if (cmd.mode == dss_pkg::MODE_CLEAR) begin
				for (int t = 0; t < TRACKS; t++)
					grid_q[t] <= '0;
			end else if (cmd.mode == dss_pkg::MODE_TOGGLE && in_cell_ok) begin
				grid_q[TRW'(cmd.track_sel)][RW'(cmd.step_sel)] <=
					~grid_q[TRW'(cmd.track_sel)][RW'(cmd.step_sel)];
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= dss_pkg::GATE_RESET;
			vel_q  <= dss_pkg::VELOCITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dss_pkg::REG_GATE_LENGTH:   gate_q <= cfg_data[7:0];
				dss_pkg::REG_NOTE_VELOCITY: vel_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Command latch and step reduction stages
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cnt_q     <= cmd.step_count;
			iter_q    <= '0;
			trk_sel_q <= cmd.track_sel;
			stp_sel_q <= cmd.step_sel;
		end else if (ctl.mod_run) begin
			fold_q <= fold_next;
			quo_q  <= quo_next;
			rem_q  <= rem_next;
			iter_q <= iter_q + dss_pkg::ITER_W'(1);
		end
	end

	// Pending tracks of the current step or stop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			kind_q <= dss_pkg::KIND_TRIG;
		end else if (ctl.load) begin
			if (cmd.mode == dss_pkg::MODE_STOP) begin
				pend_q <= '1;
				kind_q <= dss_pkg::KIND_OFF;
			end else begin
				pend_q <= '0;
				kind_q <= dss_pkg::KIND_TRIG;
			end
		end else if (ctl.col_load) begin
			pend_q <= col_vec;
		end else if (ctl.emit) begin
			pend_q <= pend_rest;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit || ctl.emit_query)
			out_valid_q <= 1'b1;
		else if (note_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.kind      <= kind_q;
			out_q.track_out <= 3'(low_idx);
			out_q.cell_on   <= 1'b0;
			out_q.last      <= (pend_rest == '0);
			if (kind_q == dss_pkg::KIND_TRIG) begin
				out_q.velocity_out <= vel_q;
				out_q.gate_out     <= gate_q;
			end else begin
				out_q.velocity_out <= '0;
				out_q.gate_out     <= '0;
			end
		end else if (ctl.emit_query) begin
			out_q.kind         <= dss_pkg::KIND_QUERY;
			out_q.track_out    <= trk_sel_q;
			out_q.velocity_out <= '0;
			out_q.gate_out     <= '0;
			out_q.cell_on      <= q_cell;
			out_q.last         <= 1'b1;
		end
	end

	assign note_valid = out_valid_q;
	assign note       = out_q;

endmodule
